// File: src/planar_odometry_integrator_assert.svh
// Assertion macros shared by the odometry integrator RTL.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_ASSERT_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define POI_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define POI_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: src/poi_pkg.sv
// Package with the types, constants and helper functions of the odometry integrator.
`timescale 1ns / 1ps
`default_nettype none

package poi_pkg;

  // Field and datapath widths.
  localparam int SPEED_W    = 16;
  localparam int DT_W       = 16;
  localparam int POS_W      = 32;
  localparam int ANG_W      = 32;
  localparam int QUAT_W     = 16;
  localparam int TRIG_W     = 32;
  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = 17;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = 66;
  localparam int PART_SHIFT = 16;

  // CORDIC configuration.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int ATAN_IDX_W       = 5;

  // Fixed-point constants.
  localparam logic signed [TRIG_W-1:0] INV_GAIN_Q30   = 32'sd652032875;
  localparam logic        [31:0]       RAD_TO_BAM_Q30 = 32'hA2F9_836E;
  localparam logic        [ANG_W-1:0]  OCTANT_OFFSET  = 32'h2000_0000;
  localparam int POS_FRAC_SHIFT  = 42;
  localparam int HEAD_FRAC_SHIFT = 30;
  localparam logic signed [QUAT_W-1:0] QUAT_MAX = 16'sd16384;
  localparam logic signed [QUAT_W-1:0] QUAT_MIN = -16'sd16384;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TRAVEL,
    ST_TURN,
    ST_TSAVE,
    ST_HLO,
    ST_HHI,
    ST_HSUM,
    ST_HUPD,
    ST_WAITC1,
    ST_XLO,
    ST_XHI,
    ST_XSUM,
    ST_XUPD,
    ST_YHI,
    ST_YSUM,
    ST_YUPD,
    ST_WAITC2,
    ST_OUT
  } poi_state_t;

  // Commands to the CORDIC rotator.
  typedef struct packed {
    logic             start;
    logic [ANG_W-1:0] angle;
  } cordic_ctrl_t;

  // Status returned by the CORDIC rotator.
  typedef struct packed {
    logic busy;
    logic done;
  } cordic_status_t;

  // Commands to the multiply-accumulate unit.
  typedef struct packed {
    logic acc_load;
    logic acc_add;
  } mac_ctrl_t;

  // Arctangent of 2^-i as a binary angle.
  function automatic logic signed [TRIG_W-1:0] atan_bam(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [TRIG_W-1:0] val;
    case (idx)
      5'd0:    val = 32'sh2000_0000;
      5'd1:    val = 32'sh12E4_051E;
      5'd2:    val = 32'sh09FB_385B;
      5'd3:    val = 32'sh0511_11D4;
      5'd4:    val = 32'sh028B_0D43;
      5'd5:    val = 32'sh0145_D7E1;
      5'd6:    val = 32'sh00A2_F61E;
      5'd7:    val = 32'sh0051_7C55;
      5'd8:    val = 32'sh0028_BE53;
      5'd9:    val = 32'sh0014_5F2F;
      5'd10:   val = 32'sh000A_2F98;
      5'd11:   val = 32'sh0005_17CC;
      5'd12:   val = 32'sh0002_8BE6;
      5'd13:   val = 32'sh0001_45F3;
      5'd14:   val = 32'sh0000_A2FA;
      5'd15:   val = 32'sh0000_517D;
      5'd16:   val = 32'sh0000_28BE;
      5'd17:   val = 32'sh0000_145F;
      5'd18:   val = 32'sh0000_0A30;
      5'd19:   val = 32'sh0000_0518;
      5'd20:   val = 32'sh0000_028C;
      5'd21:   val = 32'sh0000_0146;
      5'd22:   val = 32'sh0000_00A3;
      5'd23:   val = 32'sh0000_0051;
      default: val = '0;
    endcase
    return val;
  endfunction

  // Round a Q2.30 value to Q1.14, half up, and clamp it to plus or minus one.
  function automatic logic signed [QUAT_W-1:0] to_q14(input logic signed [TRIG_W-1:0] v);
    logic signed [TRIG_W:0]    biased;
    logic signed [TRIG_W-16:0] r;
    biased = (TRIG_W+1)'(v) + 33'sd32768;
    r = biased[TRIG_W:16];
    if (r > 17'sd16384) begin
      return QUAT_MAX;
    end else if (r < -17'sd16384) begin
      return QUAT_MIN;
    end
    return r[QUAT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: src/poi_ifs.sv
// Valid/ready stream interfaces for the input and result channels.
`timescale 1ns / 1ps
`default_nettype none

interface poi_in_if import poi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] linear_speed;
  logic signed [SPEED_W-1:0] turn_rate;
  logic        [DT_W-1:0]    time_step;

  modport source (output valid, linear_speed, turn_rate, time_step, input ready);
  modport sink   (input valid, linear_speed, turn_rate, time_step, output ready);
endinterface

interface poi_out_if import poi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [POS_W-1:0]   pos_x;
  logic signed [POS_W-1:0]   pos_y;
  logic        [ANG_W-1:0]   heading_angle;
  logic signed [QUAT_W-1:0]  quat_z;
  logic signed [QUAT_W-1:0]  quat_w;
  logic signed [SPEED_W-1:0] speed_echo;
  logic signed [SPEED_W-1:0] rate_echo;

  modport source (output valid, pos_x, pos_y, heading_angle, quat_z, quat_w, speed_echo,
                  rate_echo, input ready);
  modport sink   (input valid, pos_x, pos_y, heading_angle, quat_z, quat_w, speed_echo,
                  rate_echo, output ready);
endinterface

`default_nettype wire

// File: src/planar_odometry_integrator.sv
// Top level of the dead-reckoning odometry integrator: sequencer, pose state and result register.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted transaction advances the pose by v*cos(heading)*dt and v*sin(heading)*dt with
// the heading from before the update, then adds omega*dt to the heading, and returns one result
// transaction with the new pose, the yaw quaternion and both speeds echoed. One transaction
// occupies the block through two passes through the single iterative CORDIC rotator: one for
// the old heading and one for half the new heading. The input is not ready during that time.
// A finished result sits in an output register, so the next transaction is taken while the
// previous result still waits. Positions saturate at the 32-bit signed limits and the heading
// wraps at one full turn.

`include "planar_odometry_integrator_assert.svh"

module planar_odometry_integrator import poi_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  poi_in_if.sink    in_chan,
  poi_out_if.source out_chan
);

  poi_state_t state_r;
  poi_state_t state_nxt;

  logic signed [SPEED_W-1:0] v_r;
  logic signed [SPEED_W-1:0] w_r;
  logic        [DT_W-1:0]    dt_r;
  logic signed [MUL_A_W-1:0] travel_r;
  logic signed [MUL_A_W-1:0] turn_r;
  logic signed [TRIG_W-1:0]  c_r;
  logic signed [TRIG_W-1:0]  s_r;
  logic signed [POS_W-1:0]   x_r;
  logic signed [POS_W-1:0]   y_r;
  logic        [ANG_W-1:0]   heading_r;

  logic                      out_valid_r;
  logic signed [POS_W-1:0]   out_x_r;
  logic signed [POS_W-1:0]   out_y_r;
  logic        [ANG_W-1:0]   out_heading_r;
  logic signed [QUAT_W-1:0]  out_qz_r;
  logic signed [QUAT_W-1:0]  out_qw_r;
  logic signed [SPEED_W-1:0] out_speed_r;
  logic signed [SPEED_W-1:0] out_rate_r;

  logic                      accept;
  logic                      out_load;
  logic                      out_blocked;
  cordic_ctrl_t              cordic_ctrl;
  cordic_status_t            cordic_st;
  logic signed [TRIG_W-1:0]  cordic_cos;
  logic signed [TRIG_W-1:0]  cordic_sin;
  mac_ctrl_t                 mac_ctrl;
  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  logic signed [ACC_W-1:0]                  acc_rnd_pos;
  logic signed [ACC_W-1:0]                  acc_rnd_head;
  logic signed [ACC_W-POS_FRAC_SHIFT-1:0]   delta_pos;
  logic        [ANG_W-1:0]                  delta_head;
  logic signed [POS_W-1:0]                  pos_base;
  logic signed [POS_W+1:0]                  pos_sum;
  logic signed [POS_W-1:0]                  pos_sat;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign out_load      = (state_r == ST_OUT) && (!out_valid_r || out_chan.ready);
  assign out_blocked   = (state_r == ST_OUT) && out_valid_r && !out_chan.ready;

  // Shared rotator for both trigonometric evaluations.
  poi_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (cordic_ctrl),
    .status  (cordic_st),
    .cos_out (cordic_cos),
    .sin_out (cordic_sin)
  );

  // Shared multiplier for every product of the update.
  poi_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod),
    .acc  (acc)
  );

  // Rounding of the accumulated products and the saturating position update.
  assign acc_rnd_pos  = acc + (ACC_W'(1) <<< (POS_FRAC_SHIFT - 1));
  assign acc_rnd_head = acc + (ACC_W'(1) <<< (HEAD_FRAC_SHIFT - 1));
  assign delta_pos    = acc_rnd_pos[ACC_W-1:POS_FRAC_SHIFT];
  assign delta_head   = acc_rnd_head[HEAD_FRAC_SHIFT+ANG_W-1:HEAD_FRAC_SHIFT];
  assign pos_base     = (state_r == ST_XUPD) ? x_r : y_r;
  assign pos_sum      = (POS_W+2)'(pos_base) + (POS_W+2)'(delta_pos);

  always_comb begin
    if (pos_sum[POS_W+1:POS_W-1] == 3'b000 || pos_sum[POS_W+1:POS_W-1] == 3'b111) begin
      pos_sat = pos_sum[POS_W-1:0];
    end else if (pos_sum[POS_W+1]) begin
      pos_sat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      pos_sat = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, operand selection and unit commands.
  always_comb begin
    state_nxt         = state_r;
    cordic_ctrl.start = 1'b0;
    cordic_ctrl.angle = heading_r;
    mac_ctrl.acc_load = 1'b0;
    mac_ctrl.acc_add  = 1'b0;
    op_a              = travel_r;
    op_b              = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cordic_ctrl.start = 1'b1;
          state_nxt         = ST_TRAVEL;
        end
      end
      ST_TRAVEL: begin
        op_a      = MUL_A_W'(v_r);
        op_b      = {1'b0, dt_r};
        state_nxt = ST_TURN;
      end
      ST_TURN: begin
        op_a      = MUL_A_W'(w_r);
        op_b      = {1'b0, dt_r};
        state_nxt = ST_TSAVE;
      end
      ST_TSAVE: begin
        state_nxt = ST_HLO;
      end
      ST_HLO: begin
        op_a      = turn_r;
        op_b      = {1'b0, RAD_TO_BAM_Q30[15:0]};
        state_nxt = ST_HHI;
      end
      ST_HHI: begin
        op_a              = turn_r;
        op_b              = {1'b0, RAD_TO_BAM_Q30[31:16]};
        mac_ctrl.acc_load = 1'b1;
        state_nxt         = ST_HSUM;
      end
      ST_HSUM: begin
        mac_ctrl.acc_add = 1'b1;
        state_nxt        = ST_HUPD;
      end
      ST_HUPD: begin
        state_nxt = ST_WAITC1;
      end
      ST_WAITC1: begin
        if (!cordic_st.busy) begin
          state_nxt = ST_XLO;
        end
      end
      ST_XLO: begin
        cordic_ctrl.start = 1'b1;
        cordic_ctrl.angle = heading_r >> 1;
        op_b              = {1'b0, c_r[15:0]};
        state_nxt         = ST_XHI;
      end
      ST_XHI: begin
        op_b              = {c_r[TRIG_W-1], c_r[TRIG_W-1:16]};
        mac_ctrl.acc_load = 1'b1;
        state_nxt         = ST_XSUM;
      end
      ST_XSUM: begin
        mac_ctrl.acc_add = 1'b1;
        state_nxt        = ST_XUPD;
      end
      ST_XUPD: begin
        op_b      = {1'b0, s_r[15:0]};
        state_nxt = ST_YHI;
      end
      ST_YHI: begin
        op_b              = {s_r[TRIG_W-1], s_r[TRIG_W-1:16]};
        mac_ctrl.acc_load = 1'b1;
        state_nxt         = ST_YSUM;
      end
      ST_YSUM: begin
        mac_ctrl.acc_add = 1'b1;
        state_nxt        = ST_YUPD;
      end
      ST_YUPD: begin
        state_nxt = ST_WAITC2;
      end
      ST_WAITC2: begin
        if (!cordic_st.busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Pose state and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r       <= '0;
      y_r       <= '0;
      heading_r <= '0;
    end else begin
      if (accept) begin
        v_r  <= in_chan.linear_speed;
        w_r  <= in_chan.turn_rate;
        dt_r <= in_chan.time_step;
      end
      if (state_r == ST_TURN) begin
        travel_r <= prod[MUL_A_W-1:0];
      end
      if (state_r == ST_TSAVE) begin
        turn_r <= prod[MUL_A_W-1:0];
      end
      if (state_r == ST_HUPD) begin
        heading_r <= heading_r + delta_head;
      end
      if (state_r == ST_WAITC1 && !cordic_st.busy) begin
        c_r <= cordic_cos;
        s_r <= cordic_sin;
      end
      if (state_r == ST_XUPD) begin
        x_r <= pos_sat;
      end
      if (state_r == ST_YUPD) begin
        y_r <= pos_sat;
      end
    end
  end

  // Result register: loaded once the previous result has been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r   <= 1'b1;
        out_x_r       <= x_r;
        out_y_r       <= y_r;
        out_heading_r <= heading_r;
        out_qz_r      <= to_q14(cordic_sin);
        out_qw_r      <= to_q14(cordic_cos);
        out_speed_r   <= v_r;
        out_rate_r    <= w_r;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.pos_x         = out_x_r;
  assign out_chan.pos_y         = out_y_r;
  assign out_chan.heading_angle = out_heading_r;
  assign out_chan.quat_z        = out_qz_r;
  assign out_chan.quat_w        = out_qw_r;
  assign out_chan.speed_echo    = out_speed_r;
  assign out_chan.rate_echo     = out_rate_r;

  // Checks on the sequencer and its use of the rotator.
  `POI_ASSERT_IMP(a_start_when_free, cordic_ctrl.start, !cordic_st.busy, "CORDIC start while busy")
  `POI_ASSERT_NXT(a_accept_starts, accept, cordic_st.busy, "Transaction did not start the CORDIC")
  `POI_ASSERT_IMP(a_done_not_busy, cordic_st.done, !cordic_st.busy, "CORDIC done while busy")
  `POI_ASSERT_NXT(a_heading_hold, state_r != ST_HUPD, $stable(heading_r), "Heading moved early")
  `POI_ASSERT_NXT(a_result_wait, out_blocked, state_r == ST_OUT, "Result overwritten")

endmodule

`default_nettype wire

// File: src/poi_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle in Q2.30.
`timescale 1ns / 1ps
`default_nettype none

module poi_cordic import poi_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cordic_ctrl_t             ctrl,
  output cordic_status_t           status,
  output logic signed [TRIG_W-1:0] cos_out,
  output logic signed [TRIG_W-1:0] sin_out
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  logic                     busy_r;
  logic                     done_r;
  logic [STEP_W-1:0]        step_r;
  logic [1:0]               quad_r;
  logic signed [TRIG_W-1:0] x_r;
  logic signed [TRIG_W-1:0] y_r;
  logic signed [TRIG_W-1:0] z_r;

  logic [ANG_W-1:0]         biased_angle;
  logic [1:0]               quad_start;
  logic [ANG_W-1:0]         reduced_angle;
  logic signed [TRIG_W-1:0] x_shift;
  logic signed [TRIG_W-1:0] y_shift;
  logic signed [TRIG_W-1:0] atan_step;

  // Quadrant reduction of the start angle to the octant pair around zero.
  assign biased_angle  = ctrl.angle + OCTANT_OFFSET;
  assign quad_start    = biased_angle[ANG_W-1:ANG_W-2];
  assign reduced_angle = ctrl.angle - {quad_start, {(ANG_W-2){1'b0}}};

  // Shifted operands and the angle constant of the current iteration.
  assign x_shift   = x_r >>> step_r;
  assign y_shift   = y_r >>> step_r;
  assign atan_step = atan_bam(ATAN_IDX_W'(step_r));

  // Sequencing and the single micro-rotation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        quad_r <= quad_start;
        x_r    <= INV_GAIN_Q30;
        y_r    <= '0;
        z_r    <= reduced_angle;
      end else if (busy_r) begin
        if (!z_r[TRIG_W-1]) begin
          x_r <= x_r - y_shift;
          y_r <= y_r + x_shift;
          z_r <= z_r - atan_step;
        end else begin
          x_r <= x_r + y_shift;
          y_r <= y_r - x_shift;
          z_r <= z_r + atan_step;
        end
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  // Quadrant rotation of the result.
  always_comb begin
    case (quad_r)
      2'd0: begin
        cos_out = x_r;
        sin_out = y_r;
      end
      2'd1: begin
        cos_out = -y_r;
        sin_out = x_r;
      end
      2'd2: begin
        cos_out = -x_r;
        sin_out = -y_r;
      end
      default: begin
        cos_out = y_r;
        sin_out = -x_r;
      end
    endcase
  end

  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

`default_nettype wire

// File: src/poi_mac.sv
// Shared signed 32 x 17 multiplier with a registered product and a wide accumulator.
`timescale 1ns / 1ps
`default_nettype none

module poi_mac import poi_pkg::*; (
  input  logic                      clk,
  input  mac_ctrl_t                 ctrl,
  input  logic signed [MUL_A_W-1:0] op_a,
  input  logic signed [MUL_B_W-1:0] op_b,
  output logic signed [PROD_W-1:0]  prod,
  output logic signed [ACC_W-1:0]   acc
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_ext = ACC_W'(prod_r);

  // The product is registered every cycle; the accumulator combines two partial products.
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (ctrl.acc_load) begin
      acc_r <= prod_ext;
    end else if (ctrl.acc_add) begin
      acc_r <= acc_r + (prod_ext <<< PART_SHIFT);
    end
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

`default_nettype wire
